// ===== hdl/svrg_pkg.sv =====
// Shared types and constants for the stereo vocal remover with noise gate.
// Holds register indexes, mode codes, fixed widths and the controller/datapath
// command and status structs. No dependencies.
package svrg_pkg;

    // Default values for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Fixed widths of the configuration registers.
    localparam int MODE_WIDTH      = 3;
    localparam int GAIN_REG_WIDTH  = 17;
    localparam int THR_WIDTH       = 23;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 23;

    // Lowpass state and its coefficient, 0.02 in Q0.16.
    localparam int LP_WIDTH     = 32;
    localparam int LP_COEF      = 1311;
    localparam int LP_COEF_BITS = 16;

    localparam logic [GAIN_REG_WIDTH-1:0] VOCAL_STRENGTH_RESET = 17'd52429;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KARAOKE_MODE   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VOCAL_STRENGTH = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GATE_ENABLE    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GATE_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GATE_STRENGTH  = 3'd4;

    // Karaoke treatments.
    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_OFF      = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_ISOLATE  = 3'd2,
        MODE_EXTRACT  = 3'd3,
        MODE_ADVANCED = 3'd4
    } mode_t;

    // Operand pairs for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_LPL,
        MUL_LPR,
        MUL_MID,
        MUL_GATE_L,
        MUL_GATE_R
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd_lpl;
        logic     upd_lpr;
        logic     load_res;
        logic     gate_l;
        logic     gate_r;
        logic     load_out;
    } svrg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic                  gate_hit;
    } svrg_status_t;

endpackage

// ===== hdl/svrg_ctrl.sv =====
// Controller state machine for the stereo vocal remover gate.
// Sequences the shared multiplier steps and owns both stream handshakes.
// Depends on svrg_pkg.
module svrg_ctrl
    import svrg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  svrg_status_t status,
    output svrg_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LPL,
        S_LPR,
        S_LPW,
        S_MID,
        S_RES,
        S_GCHK,
        S_GR,
        S_GW,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   accept;
    logic   out_free;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign accept   = s_tvalid && s_tready_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and datapath commands.
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_MID;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    case (status.mode)
                        MODE_ADVANCED: state_next = S_LPL;
                        MODE_REMOVE:   state_next = S_MID;
                        MODE_ISOLATE:  state_next = S_MID;
                        default:       state_next = S_RES;
                    endcase
                end
            end
            S_LPL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LPL;
                state_next  = S_LPR;
            end
            S_LPR: begin
                cmd.upd_lpl = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LPR;
                state_next  = S_LPW;
            end
            S_LPW: begin
                cmd.upd_lpr = 1'b1;
                state_next  = S_MID;
            end
            S_MID: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MID;
                state_next  = S_RES;
            end
            S_RES: begin
                cmd.load_res = 1'b1;
                state_next   = S_GCHK;
            end
            S_GCHK: begin
                if (status.gate_hit) begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_GATE_L;
                    state_next  = S_GR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_GR: begin
                cmd.gate_l  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GATE_R;
                state_next  = S_GW;
            end
            S_GW: begin
                cmd.gate_r = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == S_IDLE);
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("output register loaded while a result is pending");

    // Ready is offered only while waiting for a new sample pair.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready_reg |-> (state_reg == S_IDLE))
        else $error("input ready outside the idle state");

    // An accepted transaction starts the sequence at once.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (!s_tready_reg && state_reg != S_IDLE))
        else $error("block stayed ready after accepting a pair");

    // The second gate product always follows the gate decision.
    a_gate_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GR) |-> ($past(state_reg) == S_GCHK))
        else $error("gate step entered out of order");

endmodule

// ===== hdl/svrg_datapath.sv =====
// Datapath of the stereo vocal remover gate: configuration registers,
// lowpass state, one shared signed multiplier, rounding and saturation.
// Depends on svrg_pkg.
module svrg_datapath
    import svrg_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  svrg_cmd_t                   cmd,
    output svrg_status_t                status,
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0] in_left,
    input  logic signed [SAMPLE_WIDTH-1:0] in_right,
    output logic signed [SAMPLE_WIDTH-1:0] out_left,
    output logic signed [SAMPLE_WIDTH-1:0] out_right
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int G      = GAIN_FRAC_BITS;
    localparam int GW     = G + 1;
    localparam int LE     = LP_WIDTH - SW;
    localparam int K      = LE + G + 1;
    localparam int COEF_W = $clog2(LP_COEF + 1);
    localparam int AW     = LP_WIDTH + 2;
    localparam int BW     = ((GW > COEF_W) ? GW : COEF_W) + 1;
    localparam int PW     = AW + BW;
    localparam int WW     = PW + 2;
    localparam int TH_REF = THR_WIDTH + 1;
    localparam int TH_UP  = (SW >= TH_REF) ? SW - TH_REF : 0;
    localparam int TH_DN  = (SW >= TH_REF) ? 0 : TH_REF - SW;

    localparam logic [GW-1:0] ONE_G = GW'(1) << G;
    localparam logic signed [WW-1:0] HALF_G1 = WW'(1) <<< G;
    localparam logic signed [WW-1:0] HALF_G  = WW'(1) <<< (G - 1);
    localparam logic signed [WW-1:0] HALF_K  = WW'(1) <<< (K - 1);
    localparam logic signed [WW-1:0] HALF_LP = WW'(1) <<< (LP_COEF_BITS - 1);
    localparam logic signed [WW-1:0] ONE_W   = WW'(1);
    localparam logic signed [WW-1:0] SW_MAX  = (WW'(1) <<< (SW - 1)) - ONE_W;
    localparam logic signed [WW-1:0] SW_MIN  = -(WW'(1) <<< (SW - 1));
    localparam logic signed [WW-1:0] LP_MAX  = (WW'(1) <<< (LP_WIDTH - 1)) - ONE_W;
    localparam logic signed [WW-1:0] LP_MIN  = -(WW'(1) <<< (LP_WIDTH - 1));
    localparam logic signed [BW-1:0] COEF_B  = BW'(LP_COEF);

    // Saturate a wide value to the sample width.
    function automatic logic signed [SW-1:0] sat_sw(input logic signed [WW-1:0] x);
        logic signed [WW-1:0] y;
        y = (x > SW_MAX) ? SW_MAX : ((x < SW_MIN) ? SW_MIN : x);
        return SW'(y);
    endfunction

    // Saturate a wide value to the lowpass width.
    function automatic logic signed [LP_WIDTH-1:0] sat_lp(input logic signed [WW-1:0] x);
        logic signed [WW-1:0] y;
        y = (x > LP_MAX) ? LP_MAX : ((x < LP_MIN) ? LP_MIN : x);
        return LP_WIDTH'(y);
    endfunction

    logic [MODE_WIDTH-1:0]     mode_reg;
    logic [GAIN_REG_WIDTH-1:0] vocal_reg;
    logic                      gate_en_reg;
    logic [THR_WIDTH-1:0]      thr_reg;
    logic [GAIN_REG_WIDTH-1:0] gate_str_reg;

    logic signed [SW-1:0]       l_reg, r_reg;
    logic signed [LP_WIDTH-1:0] lpl_reg, lpr_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [SW-1:0]       resl_reg, resr_reg;
    logic signed [SW-1:0]       outl_reg, outr_reg;

    logic [GW-1:0]        vs_gain, gs_clamp, gate_gain;
    logic signed [AW-1:0] dl, dr, a_sel;
    logic signed [BW-1:0] b_sel;
    logic signed [WW-1:0] prod_w, lw, rw, xl, xr, mid_w;
    logic signed [SW-1:0] resl_next, resr_next;
    logic [SW-1:0]        mag_l, mag_r, lvl;
    logic [SW-2:0]        th;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_OFF;
            vocal_reg    <= VOCAL_STRENGTH_RESET;
            gate_en_reg  <= 1'b0;
            thr_reg      <= '0;
            gate_str_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KARAOKE_MODE:   mode_reg     <= cfg_wdata[MODE_WIDTH-1:0];
                CFG_VOCAL_STRENGTH: vocal_reg    <= cfg_wdata[GAIN_REG_WIDTH-1:0];
                CFG_GATE_ENABLE:    gate_en_reg  <= cfg_wdata[0];
                CFG_GATE_THRESHOLD: thr_reg      <= cfg_wdata[THR_WIDTH-1:0];
                CFG_GATE_STRENGTH:  gate_str_reg <= cfg_wdata[GAIN_REG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Gains clamped to one; the gate gain is one minus its strength.
    assign vs_gain   = (32'(vocal_reg) > 32'(ONE_G)) ? ONE_G : GW'(vocal_reg);
    assign gs_clamp  = (32'(gate_str_reg) > 32'(ONE_G)) ? ONE_G : GW'(gate_str_reg);
    assign gate_gain = ONE_G - gs_clamp;

    // High-pass differences against the current lowpass state.
    assign dl = (AW'(l_reg) <<< LE) - AW'(lpl_reg);
    assign dr = (AW'(r_reg) <<< LE) - AW'(lpr_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        case (cmd.mul_sel)
            MUL_LPL: begin
                a_sel = dl;
                b_sel = COEF_B;
            end
            MUL_LPR: begin
                a_sel = dr;
                b_sel = COEF_B;
            end
            MUL_GATE_L: begin
                a_sel = AW'(resl_reg);
                b_sel = signed'(BW'(gate_gain));
            end
            MUL_GATE_R: begin
                a_sel = AW'(resr_reg);
                b_sel = signed'(BW'(gate_gain));
            end
            default: begin
                a_sel = (mode_reg == MODE_ADVANCED) ? (dl + dr)
                                                    : (AW'(l_reg) + AW'(r_reg));
                b_sel = signed'(BW'(vs_gain));
            end
        endcase
    end

    // Input capture and product register.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            l_reg <= in_left;
            r_reg <= in_right;
        end
        if (cmd.mul_en) begin
            prod_reg <= a_sel * b_sel;
        end
    end

    assign prod_w = WW'(prod_reg);
    assign lw     = WW'(l_reg);
    assign rw     = WW'(r_reg);

    // Lowpass state: lp plus the rounded coefficient product, saturated.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpl_reg <= '0;
            lpr_reg <= '0;
        end else begin
            if (cmd.upd_lpl) begin
                lpl_reg <= sat_lp(WW'(lpl_reg) + ((prod_w + HALF_LP) >>> LP_COEF_BITS));
            end
            if (cmd.upd_lpr) begin
                lpr_reg <= sat_lp(WW'(lpr_reg) + ((prod_w + HALF_LP) >>> LP_COEF_BITS));
            end
        end
    end

    // Treatment results, each rounded once with halves toward plus infinity; off mode passes the inputs through.
    always_comb begin
        xl    = '0;
        xr    = '0;
        mid_w = '0;
        case (mode_reg)
            MODE_REMOVE: begin
                xl = ((((lw <<< 1) + lw - rw)) <<< G) - prod_w;
                xr = ((((rw <<< 1) + rw - lw)) <<< G) - prod_w;
                resl_next = sat_sw((xl + HALF_G1) >>> (G + 1));
                resr_next = sat_sw((xr + HALF_G1) >>> (G + 1));
            end
            MODE_ISOLATE: begin
                mid_w     = (prod_w + HALF_G1) >>> (G + 1);
                resl_next = sat_sw(mid_w);
                resr_next = sat_sw(mid_w);
            end
            MODE_EXTRACT: begin
                mid_w     = (lw + rw + ONE_W) >>> 1;
                resl_next = sat_sw(mid_w);
                resr_next = sat_sw(mid_w);
            end
            MODE_ADVANCED: begin
                xl = (lw <<< K) - prod_w;
                xr = (rw <<< K) - prod_w;
                resl_next = sat_sw((xl + HALF_K) >>> K);
                resr_next = sat_sw((xr + HALF_K) >>> K);
            end
            default: begin
                resl_next = l_reg;
                resr_next = r_reg;
            end
        endcase
    end

    // Result registers, then the gate products written back over them.
    always_ff @(posedge aclk) begin
        if (cmd.load_res) begin
            resl_reg <= resl_next;
            resr_reg <= resr_next;
        end else begin
            if (cmd.gate_l) begin
                resl_reg <= sat_sw((prod_w + HALF_G) >>> G);
            end
            if (cmd.gate_r) begin
                resr_reg <= sat_sw((prod_w + HALF_G) >>> G);
            end
        end
        if (cmd.load_out) begin
            outl_reg <= resl_reg;
            outr_reg <= resr_reg;
        end
    end

    // Gate decision: peak magnitude against the rescaled threshold.
    assign mag_l = resl_reg[SW-1] ? SW'(-resl_reg) : SW'(resl_reg);
    assign mag_r = resr_reg[SW-1] ? SW'(-resr_reg) : SW'(resr_reg);
    assign lvl   = (mag_l > mag_r) ? mag_l : mag_r;
    assign th    = (SW-1)'((32'(thr_reg) << TH_UP) >> TH_DN);

    assign status.mode     = mode_reg;
    assign status.gate_hit = gate_en_reg && (lvl < {1'b0, th});

    assign out_left  = outl_reg;
    assign out_right = outr_reg;

endmodule

// ===== hdl/stereo_vocal_remover_gate.sv =====
// Top level of the stereo vocal remover with noise gate.
// Joins the controller and the datapath; depends on svrg_pkg, svrg_ctrl
// and svrg_datapath.
//
// Usage: one stereo sample pair enters per transaction on the s_ channel and
// one processed pair leaves per transaction on the m_ channel. Registers are
// written through cfg_wr_en, cfg_index and cfg_wdata while no pair is in work.
// Sequence: off and center extraction modes go straight to the result step,
// removal and isolation first take the mid gain product, and advanced removal
// first takes the two lowpass products and then the mid gain; the two gate
// products follow whenever the noise gate attenuates the pair. The single
// shared multiplier serves the two lowpass updates, the mid gain and the two
// gate products one after another. The result becomes valid in the same cycle
// that s_tready returns, once the output register is free.
// The result sits in an output register, so a new pair is accepted while the
// previous result still waits; if the receiver keeps m_tready low, the block
// finishes the next pair and then holds it until the register frees up.
// Reset (aresetn low at a clock edge) clears the registers to their defaults,
// zeroes the lowpass state and drops m_tvalid; s_tready is high after reset.
module stereo_vocal_remover_gate
    import svrg_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int TDATA_WIDTH   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [TDATA_WIDTH-1:0]     s_tdata,   // left_sample, right_sample
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [TDATA_WIDTH-1:0]     m_tdata,   // left_result, right_result
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    svrg_cmd_t                      cmd;
    svrg_status_t                   status;
    logic signed [SAMPLE_WIDTH-1:0] out_left, out_right;

    svrg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    svrg_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_left   (s_tdata[SAMPLE_WIDTH-1:0]),
        .in_right  (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .out_left  (out_left),
        .out_right (out_right)
    );

    // Pack the result pair, left in the low bits, zero padding on top.
    assign m_tdata = TDATA_WIDTH'({out_right, out_left});

endmodule
